FILE: sv/sfs_pkg.sv
// Shared types and constants for the stop-and-wait frame sender.
package sfs_pkg;

    // Default frame length in data bytes
    localparam int SFS_FRAME_BYTES = 8;

    // Configuration port geometry
    localparam int SFS_ADDR_W = 3;
    localparam int SFS_DATA_W = 32;

    // Register indexes, taken from paddr[2]
    localparam logic REG_TIMEOUT_TICKS = 1'b0;
    localparam logic REG_RETRY_LIMIT   = 1'b1;

    // Reset values of the configuration registers
    localparam logic [15:0] TIMEOUT_RESET     = 16'd1;
    localparam logic [3:0]  RETRY_LIMIT_RESET = 4'd5;

    // Saturation limit of the retry counter
    localparam logic [3:0] RETRY_MAX = 4'd15;

    // Input item opcodes
    typedef enum logic [1:0] {
        OP_BYTE  = 2'd0,
        OP_ACK   = 2'd1,
        OP_TICK  = 2'd2,
        OP_SPARE = 2'd3
    } sfs_op_t;

    // Result status codes
    typedef enum logic [1:0] {
        STS_SENT     = 2'd0,
        STS_REFUSED  = 2'd1,
        STS_ACKED    = 2'd2,
        STS_GAVE_UP  = 2'd3
    } sfs_sts_t;

    // Input item
    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] data_byte;
        logic       last_byte;
    } item_t;

    // Result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_frame;
        logic [1:0] status;
        logic [3:0] attempt;
    } result_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic store_byte;   // write payload byte into frame store
        logic new_frame;    // fresh frame: retry count clears
        logic start_frame;  // begin a (re)transmission
        logic retx;         // timeout with retries left
        logic tick_dec;     // count the wait timer down
        logic ack;          // frame acknowledged
        logic give_up;      // out of retries
        logic refuse;       // byte refused while waiting
        logic send_step;    // load next frame byte into result register
    } sfs_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic phase;        // 1 while waiting for an ack
        logic full_next;    // next stored byte fills the frame
        logic expire;       // next tick ends the wait
        logic give_up_next; // next timeout exhausts retries
        logic send_last;    // send index is on the checksum byte
    } sfs_stat_t;

endpackage

FILE: sv/stop_and_wait_frame_sender_core.sv
// Top level of the stop-and-wait frame sender: configuration registers and module wiring.
//
//   channel   handshake                    payload
//   item      item_valid / item_stall      item   (opcode, data_byte, last_byte)
//   result    result_valid / result_stall  result (out_byte, last_of_frame, status, attempt)
//   config    psel / penable / pready      paddr, pwdata, prdata
//
// Refused bytes, acks and give-up ticks yield one result each, offered in the next cycle.
// A frame goes out as FRAME_BYTES+1 transfers, one per cycle unless the result is stalled, through the result register;
// the frame store is read at the send index, and no item is taken until the checksum is loaded.
// Reset clears the fill count, checksum, timer, retry count and phase; the store needs none.
// A stalled result register holds and also stalls the item channel.
module stop_and_wait_frame_sender_core #(
    parameter int FRAME_BYTES = sfs_pkg::SFS_FRAME_BYTES
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  sfs_pkg::item_t                item,
    output logic                          result_valid,
    input  logic                          result_stall,
    output sfs_pkg::result_t              result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sfs_pkg::SFS_ADDR_W-1:0] paddr,
    input  logic [sfs_pkg::SFS_DATA_W-1:0] pwdata,
    output logic [sfs_pkg::SFS_DATA_W-1:0] prdata,
    output logic                          pready
);
    import sfs_pkg::*;

    logic [15:0] timeout_reg;
    logic [3:0]  retry_limit_reg;
    logic        cfg_write;
    sfs_cmd_t    cmd;
    sfs_stat_t   stat;

    // Configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg     <= TIMEOUT_RESET;
            retry_limit_reg <= RETRY_LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_TIMEOUT_TICKS)
            begin
                timeout_reg <= pwdata[15:0];
            end
            else
            begin
                retry_limit_reg <= pwdata[3:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_RETRY_LIMIT) ?
                    {{(SFS_DATA_W - 4){1'b0}}, retry_limit_reg} :
                    {{(SFS_DATA_W - 16){1'b0}}, timeout_reg};

    // Controller
    sfs_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .opcode       (item.opcode),
        .last_byte    (item.last_byte),
        .result_stall (result_stall),
        .stat         (stat),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .cmd          (cmd)
    );

    // Datapath
    sfs_datapath #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .data_byte     (item.data_byte),
        .timeout_ticks (timeout_reg),
        .retry_limit   (retry_limit_reg),
        .stat          (stat),
        .result        (result)
    );

endmodule

FILE: sv/sfs_ctrl.sv
// Controller state machine: handshakes, command decode and frame send sequencing.
module sfs_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic [1:0]        opcode,
    input  logic              last_byte,
    input  logic              result_stall,
    input  sfs_pkg::sfs_stat_t stat,
    output logic              item_stall,
    output logic              result_valid,
    output sfs_pkg::sfs_cmd_t  cmd
);
    import sfs_pkg::*;

    typedef enum logic {
        S_READY,
        S_SEND
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   valid_reg;
    logic   valid_next;
    logic   out_free;
    logic   accept;
    logic   is_byte;
    logic   is_ack;
    logic   is_tick;
    logic   load;

    // Result register can take a new transfer this cycle
    assign out_free   = !valid_reg || !result_stall;
    assign item_stall = !((state_reg == S_READY) && out_free);
    assign accept     = item_valid && !item_stall;

    assign is_byte = (opcode == OP_BYTE);
    assign is_ack  = (opcode == OP_ACK);
    assign is_tick = (opcode == OP_TICK);

    // Command decode
    always_comb
    begin
        cmd             = '0;
        cmd.store_byte  = accept && is_byte && !stat.phase;
        cmd.new_frame   = cmd.store_byte && (stat.full_next || last_byte);
        cmd.refuse      = accept && is_byte && stat.phase;
        cmd.ack         = accept && is_ack && stat.phase;
        cmd.tick_dec    = accept && is_tick && stat.phase && !stat.expire;
        cmd.give_up     = accept && is_tick && stat.phase && stat.expire
                          && stat.give_up_next;
        cmd.retx        = accept && is_tick && stat.phase && stat.expire
                          && !stat.give_up_next;
        cmd.start_frame = cmd.new_frame || cmd.retx;
        cmd.send_step   = (state_reg == S_SEND) && out_free;
    end

    assign load = cmd.refuse || cmd.ack || cmd.give_up || cmd.send_step;

    // Next state and result valid
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_READY:
            begin
                if (cmd.start_frame)
                begin
                    state_next = S_SEND;
                end
            end
            S_SEND:
            begin
                if (cmd.send_step && stat.send_last)
                begin
                    state_next = S_READY;
                end
            end
            default:
            begin
                state_next = S_READY;
            end
        endcase

        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_READY;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    assign result_valid = valid_reg;

    // No item is taken while a frame goes out
    a_no_accept_in_send: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEND) |-> item_stall)
        else $error("item accepted during frame send");

    // A frame start leads into the send sequence
    a_start_sends: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start_frame |=> (state_reg == S_SEND))
        else $error("frame start did not enter send");

    // At most one single-result or timer action per item
    a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.refuse, cmd.ack, cmd.give_up, cmd.retx, cmd.tick_dec,
                  cmd.store_byte}))
        else $error("conflicting commands");

    // The checksum transfer closes the send sequence
    a_send_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.send_step && stat.send_last) |=> (state_reg == S_READY))
        else $error("send did not end after checksum");

    // A loaded result is offered in the next cycle
    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> result_valid)
        else $error("loaded result not valid");

endmodule

FILE: sv/sfs_datapath.sv
// Datapath: frame store, checksum, fill count, wait timer, retry count and result register.
module sfs_datapath #(
    parameter int FRAME_BYTES = sfs_pkg::SFS_FRAME_BYTES
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  sfs_pkg::sfs_cmd_t  cmd,
    input  logic [7:0]        data_byte,
    input  logic [15:0]       timeout_ticks,
    input  logic [3:0]        retry_limit,
    output sfs_pkg::sfs_stat_t stat,
    output sfs_pkg::result_t   result
);
    import sfs_pkg::*;

    localparam int CNT_W = $clog2(FRAME_BYTES + 1);
    localparam int IDX_W = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;

    logic [7:0]       store [FRAME_BYTES];
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic [7:0]       sum_reg;
    logic [7:0]       sum_next;
    logic             phase_reg;
    logic             phase_next;
    logic [15:0]      timer_reg;
    logic [15:0]      timer_next;
    logic [3:0]       retry_reg;
    logic [3:0]       retry_next;
    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] idx_next;
    logic [3:0]       retry_inc;
    result_t          result_reg;

    // Saturating retry increment and status to the controller
    assign retry_inc = (retry_reg == RETRY_MAX) ? RETRY_MAX : retry_reg + 4'd1;

    assign stat.phase        = phase_reg;
    assign stat.full_next    = (fill_reg == CNT_W'(FRAME_BYTES - 1));
    assign stat.expire       = (timer_reg <= 16'd1);
    assign stat.give_up_next = (retry_inc >= retry_limit);
    assign stat.send_last    = (idx_reg == CNT_W'(FRAME_BYTES));

    // Next values of the frame and wait state
    always_comb
    begin
        fill_next  = fill_reg;
        sum_next   = sum_reg;
        phase_next = phase_reg;
        timer_next = timer_reg;
        retry_next = retry_reg;
        idx_next   = idx_reg;

        if (cmd.store_byte)
        begin
            fill_next = fill_reg + CNT_W'(1);
            sum_next  = sum_reg + data_byte;
        end
        if (cmd.new_frame)
        begin
            retry_next = 4'd0;
        end
        if (cmd.retx)
        begin
            retry_next = retry_inc;
        end
        if (cmd.start_frame)
        begin
            phase_next = 1'b1;
            timer_next = timeout_ticks;
            idx_next   = '0;
        end
        if (cmd.tick_dec)
        begin
            timer_next = timer_reg - 16'd1;
        end
        if (cmd.ack || cmd.give_up)
        begin
            phase_next = 1'b0;
            fill_next  = '0;
            sum_next   = 8'd0;
            retry_next = 4'd0;
            timer_next = 16'd0;
        end
        if (cmd.send_step && !stat.send_last)
        begin
            idx_next = idx_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            sum_reg   <= 8'd0;
            phase_reg <= 1'b0;
            timer_reg <= 16'd0;
            retry_reg <= 4'd0;
            idx_reg   <= '0;
        end
        else
        begin
            fill_reg  <= fill_next;
            sum_reg   <= sum_next;
            phase_reg <= phase_next;
            timer_reg <= timer_next;
            retry_reg <= retry_next;
            idx_reg   <= idx_next;
        end
    end

    // Frame store write
    always_ff @(posedge clk)
    begin
        if (cmd.store_byte)
        begin
            store[fill_reg[IDX_W-1:0]] <= data_byte;
        end
    end

    // Result register; bytes past the fill count are zero padding
    always_ff @(posedge clk)
    begin
        priority if (cmd.send_step)
        begin
            result_reg.status  <= STS_SENT;
            result_reg.attempt <= retry_reg;
            if (stat.send_last)
            begin
                result_reg.out_byte      <= sum_reg;
                result_reg.last_of_frame <= 1'b1;
            end
            else
            begin
                result_reg.out_byte      <= (idx_reg < fill_reg) ?
                                            store[idx_reg[IDX_W-1:0]] : 8'd0;
                result_reg.last_of_frame <= 1'b0;
            end
        end
        else if (cmd.refuse)
        begin
            result_reg <= '{8'd0, 1'b0, STS_REFUSED, retry_reg};
        end
        else if (cmd.ack)
        begin
            result_reg <= '{8'd0, 1'b0, STS_ACKED, retry_reg};
        end
        else if (cmd.give_up)
        begin
            result_reg <= '{8'd0, 1'b0, STS_GAVE_UP, retry_inc};
        end
        else
        begin
            result_reg <= result_reg;
        end
    end

    assign result = result_reg;

endmodule
